FILE: src/spn32_pkg.sv
package spn32_pkg;

  localparam int unsigned MAX_ROUNDS = 16;
  localparam int unsigned RND_W = $clog2(MAX_ROUNDS + 1);
  localparam logic [31:0] KEY_STEP = 32'h9E37_79B9;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_KEY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VECTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd4;

  localparam logic [4:0] ROUND_COUNT_RESET = 5'd5;

  localparam logic [3:0] SUB_FWD [16] = '{
    4'd4, 4'd2, 4'd12, 4'd6, 4'd15, 4'd9, 4'd5, 4'd1,
    4'd7, 4'd0, 4'd8, 4'd3, 4'd11, 4'd13, 4'd14, 4'd10
  };
  localparam logic [3:0] SUB_INV [16] = '{
    4'd9, 4'd7, 4'd1, 4'd11, 4'd0, 4'd6, 4'd3, 4'd8,
    4'd10, 4'd5, 4'd15, 4'd12, 4'd2, 4'd13, 4'd14, 4'd4
  };
  localparam logic [4:0] PERM_FWD [32] = '{
    5'd16, 5'd7, 5'd20, 5'd21, 5'd29, 5'd12, 5'd28, 5'd17,
    5'd1, 5'd15, 5'd23, 5'd26, 5'd5, 5'd18, 5'd31, 5'd10,
    5'd2, 5'd8, 5'd24, 5'd14, 5'd0, 5'd27, 5'd3, 5'd9,
    5'd19, 5'd13, 5'd30, 5'd6, 5'd22, 5'd11, 5'd4, 5'd25
  };
  localparam logic [4:0] PERM_INV [32] = '{
    5'd20, 5'd8, 5'd16, 5'd22, 5'd30, 5'd12, 5'd27, 5'd1,
    5'd17, 5'd23, 5'd15, 5'd29, 5'd5, 5'd25, 5'd19, 5'd9,
    5'd0, 5'd7, 5'd13, 5'd24, 5'd2, 5'd3, 5'd28, 5'd10,
    5'd18, 5'd31, 5'd11, 5'd21, 5'd6, 5'd4, 5'd26, 5'd14
  };

  typedef enum logic [1:0] {
    CHAIN_NONE,
    CHAIN_IV,
    CHAIN_REG
  } chain_sel_e;

  typedef struct packed {
    logic [31:0] master_key;
    logic [4:0]  round_count;
    logic [31:0] init_vector;
    logic        chain_mode;
    logic        direction;
  } cfg_t;

  typedef struct packed {
    logic [31:0] data;
    chain_sel_e  sel;
  } q_entry_t;

  function automatic logic [RND_W-1:0] rounds_used(logic [4:0] rc);
    if (32'(rc) > MAX_ROUNDS) begin
      return RND_W'(MAX_ROUNDS);
    end
    return RND_W'(rc);
  endfunction

  function automatic logic [31:0] round_key(logic [31:0] mk, logic [RND_W-1:0] i);
    logic [4:0]  rot;
    logic [63:0] both;
    logic [31:0] mul;
    rot  = 5'(32'(i));
    both = {mk, mk} >> rot;
    mul  = KEY_STEP * 32'(i);
    return both[31:0] ^ mul;
  endfunction

  function automatic logic [31:0] sub_fwd(logic [31:0] x);
    logic [31:0] r;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 4] = SUB_FWD[x[4*k +: 4]];
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_inv(logic [31:0] x);
    logic [31:0] r;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 4] = SUB_INV[x[4*k +: 4]];
    end
    return r;
  endfunction

  function automatic logic [31:0] perm_fwd(logic [31:0] x);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) begin
      r[PERM_FWD[k]] = x[k];
    end
    return r;
  endfunction

  function automatic logic [31:0] perm_inv(logic [31:0] x);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) begin
      r[PERM_INV[k]] = x[k];
    end
    return r;
  endfunction

endpackage

FILE: src/spn32_front.sv
module spn32_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spn32_pkg::cfg_t       cfg_i,
  input  logic [31:0]           data_in_i,
  input  logic                  first_block_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output spn32_pkg::q_entry_t   entry_o,
  output logic                  entry_valid_o,
  input  logic                  entry_pop_i
);

  spn32_pkg::q_entry_t mem_q [spn32_pkg::QDEPTH];
  logic [spn32_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [spn32_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  spn32_pkg::q_entry_t          new_entry;
  logic                         push, pop;

  // classify: which chain value the back end must use
  always_comb begin
    new_entry.data = data_in_i;
    if (!cfg_i.chain_mode) begin
      new_entry.sel = spn32_pkg::CHAIN_NONE;
    end else if (first_block_i) begin
      new_entry.sel = spn32_pkg::CHAIN_IV;
    end else begin
      new_entry.sel = spn32_pkg::CHAIN_REG;
    end
  end

  assign in_ready_o    = (cnt_q != spn32_pkg::QCNT_W'(spn32_pkg::QDEPTH));
  assign entry_valid_o = (cnt_q != '0);
  assign entry_o       = mem_q[rd_ptr_q];
  assign push          = in_valid_i && in_ready_o;
  assign pop           = entry_pop_i && entry_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == spn32_pkg::QPTR_W'(spn32_pkg::QDEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == spn32_pkg::QPTR_W'(spn32_pkg::QDEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

FILE: src/spn32_back.sv
module spn32_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spn32_pkg::cfg_t       cfg_i,
  input  spn32_pkg::q_entry_t   entry_i,
  input  logic                  entry_valid_i,
  output logic                  entry_pop_o,
  output logic [31:0]           data_out_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        state_q, state_d;
  logic [31:0]                 x_q, x_d;
  logic [31:0]                 data_q, data_d;
  logic [31:0]                 chain_use_q, chain_use_d;
  logic [31:0]                 chain_q, chain_d;
  spn32_pkg::chain_sel_e       sel_q, sel_d;
  logic [spn32_pkg::RND_W-1:0] rnd_q, rnd_d, left_q, left_d, n_rounds;
  logic [31:0]                 out_q, out_d;
  logic                        out_valid_q, out_valid_d;
  logic [31:0]                 chain_in, rkey, result;
  logic                        finish;

  assign n_rounds = spn32_pkg::rounds_used(cfg_i.round_count);
  assign rkey     = spn32_pkg::round_key(cfg_i.master_key, rnd_q);
  assign result   = cfg_i.direction ? (x_q ^ chain_use_q) : x_q;
  assign finish   = (state_q == ST_RUN) && (left_q == '0) && (!out_valid_q || out_ready_i);
  assign entry_pop_o = (state_q == ST_IDLE) && entry_valid_i;

  always_comb begin
    unique case (entry_i.sel)
      spn32_pkg::CHAIN_IV:  chain_in = cfg_i.init_vector;
      spn32_pkg::CHAIN_REG: chain_in = chain_q;
      default:              chain_in = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    data_d      = data_q;
    chain_use_d = chain_use_q;
    chain_d     = chain_q;
    sel_d       = sel_q;
    rnd_d       = rnd_q;
    left_d      = left_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (entry_valid_i) begin
          data_d      = entry_i.data;
          sel_d       = entry_i.sel;
          chain_use_d = chain_in;
          x_d         = cfg_i.direction ? entry_i.data : (entry_i.data ^ chain_in);
          left_d      = n_rounds;
          rnd_d       = cfg_i.direction ? (n_rounds - 1'b1) : '0;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (left_q != '0) begin
          if (cfg_i.direction) begin
            x_d   = spn32_pkg::sub_inv(spn32_pkg::perm_inv(x_q)) ^ rkey;
            rnd_d = rnd_q - 1'b1;
          end else begin
            x_d   = spn32_pkg::perm_fwd(spn32_pkg::sub_fwd(x_q ^ rkey));
            rnd_d = rnd_q + 1'b1;
          end
          left_d = left_q - 1'b1;
        end else if (finish) begin
          out_d       = result;
          out_valid_d = 1'b1;
          if (sel_q != spn32_pkg::CHAIN_NONE) begin
            chain_d = cfg_i.direction ? data_q : result;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      chain_q     <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    data_q      <= data_d;
    chain_use_q <= chain_use_d;
    sel_q       <= sel_d;
    rnd_q       <= rnd_d;
    left_q      <= left_d;
    out_q       <= out_d;
  end

  assign data_out_o  = out_q;
  assign out_valid_o = out_valid_q;

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_pop_o |=> state_q == ST_RUN)
    else $error("pop did not start a run");

  a_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> 32'(left_q) <= spn32_pkg::MAX_ROUNDS)
    else $error("round counter out of range");

  a_ecb_chain_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && sel_q == spn32_pkg::CHAIN_NONE) |=> $stable(chain_q))
    else $error("chain changed in ECB");

  a_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished item not presented");

endmodule

FILE: src/spn32_block_cipher_ecb_cbc_core.sv
// Channel   Signals                              Direction
// input     data_in_i, first_block_i             in_valid_i / in_ready_o
// output    data_out_o                           out_valid_o / out_ready_i
// config    cfg_we_i, cfg_index_i, cfg_data_i    write only, no wait
//
// An item passes through the round engine in order, n = min(round_count, 16):
// a load step, n rounds through the shared round unit, then a finish step.
// A two-entry queue takes items while the engine runs; a full output register
// holds the engine in its finish step until the result is taken.
// Reset clears configuration to its defaults, the chain register and the queue.
module spn32_block_cipher_ecb_cbc_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [spn32_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic [31:0]                        data_in_i,
  input  logic                               first_block_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  output logic [31:0]                        data_out_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i
);

  spn32_pkg::cfg_t     cfg_q, cfg_d;
  spn32_pkg::q_entry_t entry;
  logic                entry_valid, entry_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        spn32_pkg::REG_MASTER_KEY:  cfg_d.master_key  = cfg_data_i;
        spn32_pkg::REG_ROUND_COUNT: cfg_d.round_count = cfg_data_i[4:0];
        spn32_pkg::REG_INIT_VECTOR: cfg_d.init_vector = cfg_data_i;
        spn32_pkg::REG_CHAIN_MODE:  cfg_d.chain_mode  = cfg_data_i[0];
        spn32_pkg::REG_DIRECTION:   cfg_d.direction   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.master_key  <= '0;
      cfg_q.round_count <= spn32_pkg::ROUND_COUNT_RESET;
      cfg_q.init_vector <= '0;
      cfg_q.chain_mode  <= 1'b0;
      cfg_q.direction   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  spn32_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .data_in_i     (data_in_i),
    .first_block_i (first_block_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .entry_o       (entry),
    .entry_valid_o (entry_valid),
    .entry_pop_i   (entry_pop)
  );

  spn32_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_i       (entry),
    .entry_valid_i (entry_valid),
    .entry_pop_o   (entry_pop),
    .data_out_o    (data_out_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule
